// ----- src/pfde_pkg.sv -----
package pfde_pkg;

  localparam int unsigned SCREEN_WIDTH_DEF  = 128;
  localparam int unsigned SCREEN_HEIGHT_DEF = 64;

  typedef enum logic [2:0] {
    REQ_PIXEL = 3'd0,
    REQ_LINE  = 3'd1,
    REQ_RECT  = 3'd2,
    REQ_FILL  = 3'd3,
    REQ_READ  = 3'd4
  } req_t;

endpackage

// ----- src/page_framebuffer_draw_engine.sv -----
// Drawing engine for a 1-bit page-organised framebuffer held in one synchronous
// RAM of SCREEN_WIDTH * ceil(SCREEN_HEIGHT/8) bytes; pixel (x, y) is bit y%8 of
// byte x + (y/8)*SCREEN_WIDTH. One command is taken at a time and gives one
// result beat. Every pixel touched is a RAM read (S_DOT) followed by a modified
// write (S_WR); a screen fill and the clearing pass after reset write one byte
// per cycle. After reset no command is taken until the clearing pass over all
// bytes has finished.
module page_framebuffer_draw_engine
  import pfde_pkg::*;
#(
  parameter int unsigned SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
  parameter int unsigned SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // req_type[2:0], x_start[10:3], y_start[18:11], x_end[26:19], y_end[34:27],
  // ink[35], read_index[45:36], zero[47:46]
  input  logic [47:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // read_data[7:0], req_echo[10:8], zero[15:11]
  output logic [15:0] m_tdata
);

  localparam int unsigned PAGES = (SCREEN_HEIGHT + 7) / 8;
  localparam int unsigned BYTES = SCREEN_WIDTH * PAGES;
  localparam int unsigned AW    = $clog2(BYTES);

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_DOT   = 7'b0000100,
    S_WR    = 7'b0001000,
    S_FILL  = 7'b0010000,
    S_RD    = 7'b0100000,
    S_OUT   = 7'b1000000
  } state_t;

  state_t state;
  logic [7:0] mem [BYTES];
  logic [7:0] rdata;
  logic [AW-1:0] waddr, rd_addr;
  logic [7:0] fill_byte;
  logic [2:0] req;
  logic ink;
  logic [8:0] ax, ay, bx, by, rx0, rx1, ry1;
  logic signed [10:0] dx, dy, err;
  logic sxn, syn, line_first, is_line;
  logic [7:0] out_data;
  logic [AW:0] cnt;

  logic [2:0] in_req;
  logic [7:0] in_xs, in_ys, in_xe, in_ye;
  logic [9:0] in_ridx;
  assign in_req  = s_tdata[2:0];
  assign in_xs   = s_tdata[10:3];
  assign in_ys   = s_tdata[18:11];
  assign in_xe   = s_tdata[26:19];
  assign in_ye   = s_tdata[34:27];
  assign in_ridx = s_tdata[45:36];

  // current dot and its clip test
  logic [8:0] cx, cy;
  logic on_screen;
  logic [AW-1:0] dot_addr;
  logic [2:0] dot_bit;
  always_comb begin
    cx = (is_line && line_first) ? bx : ax;
    cy = (is_line && line_first) ? by : ay;
    on_screen = (cx < 9'(SCREEN_WIDTH)) && (cy < 9'(SCREEN_HEIGHT));
    dot_addr = AW'(32'(cx) + 32'(cy[8:3]) * SCREEN_WIDTH);
    dot_bit = cy[2:0];
  end

  assign rd_addr = (state == S_DOT) ? dot_addr : AW'(in_ridx);

  logic signed [11:0] e2;
  assign e2 = {err, 1'b0};
  assign s_tready = (state == S_IDLE);
  assign m_tvalid = (state == S_OUT);
  assign m_tdata  = {5'd0, req, out_data};

  logic [2:0] wbit;
  always_ff @(posedge clk) begin
    if (state == S_FILL || state == S_CLEAR) mem[cnt[AW-1:0]] <= fill_byte;
    else if (state == S_WR)
      mem[waddr] <= ink ? (rdata | (8'd1 << wbit)) : (rdata & ~(8'd1 << wbit));
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      cnt <= '0;
      fill_byte <= 8'h00;
    end else begin
      unique case (state)
        S_CLEAR, S_FILL: begin
          cnt <= cnt + 1'b1;
          if (cnt == (AW+1)'(BYTES - 1)) state <= (state == S_FILL) ? S_OUT : S_IDLE;
        end
        S_IDLE: if (s_tvalid) begin
          req <= in_req;
          ink <= s_tdata[35];
          out_data <= 8'h00;
          cnt <= '0;
          fill_byte <= s_tdata[35] ? 8'hFF : 8'h00;
          is_line <= (in_req == REQ_LINE);
          line_first <= 1'b1;
          if (in_req == REQ_LINE) begin
            ax <= {1'b0, in_xs}; ay <= {1'b0, in_ys};
            bx <= {1'b0, in_xe}; by <= {1'b0, in_ye};
            dx <= (in_xe > in_xs) ? 11'(in_xe - in_xs) : 11'(in_xs - in_xe);
            dy <= (in_ye > in_ys) ? 11'(in_ye - in_ys) : 11'(in_ys - in_ye);
            err <= ((in_xe > in_xs) ? 11'(in_xe - in_xs) : 11'(in_xs - in_xe))
                 - ((in_ye > in_ys) ? 11'(in_ye - in_ys) : 11'(in_ys - in_ye));
            sxn <= !(in_xs < in_xe);
            syn <= !(in_ys < in_ye);
          end else begin
            ax <= {1'b0, (in_req == REQ_RECT && in_xe < in_xs) ? in_xe : in_xs};
            ay <= {1'b0, (in_req == REQ_RECT && in_ye < in_ys) ? in_ye : in_ys};
            rx0 <= {1'b0, (in_xe < in_xs) ? in_xe : in_xs};
            rx1 <= ((in_xe < in_xs ? in_xs : in_xe) > 8'(SCREEN_WIDTH - 1))
                   ? 9'(SCREEN_WIDTH - 1) : {1'b0, (in_xe < in_xs) ? in_xs : in_xe};
            ry1 <= ((in_ye < in_ys ? in_ys : in_ye) > 8'(SCREEN_HEIGHT - 1))
                   ? 9'(SCREEN_HEIGHT - 1) : {1'b0, (in_ye < in_ys) ? in_ys : in_ye};
          end
          priority case (in_req)
            REQ_PIXEL, REQ_LINE: state <= S_DOT;
            REQ_RECT: state <= ((in_xe < in_xs ? in_xe : in_xs) > 8'(SCREEN_WIDTH - 1) ||
                                (in_ye < in_ys ? in_ye : in_ys) > 8'(SCREEN_HEIGHT - 1))
                               ? S_OUT : S_DOT;
            REQ_FILL: state <= S_FILL;
            REQ_READ: state <= (32'(in_ridx) < BYTES) ? S_RD : S_OUT;
            default: state <= S_OUT;
          endcase
        end
        S_DOT: begin
          waddr <= dot_addr; wbit <= dot_bit;
          state <= on_screen ? S_WR : S_DOT;
          // advance the walker
          if (req == REQ_PIXEL) begin
            if (!on_screen) state <= S_OUT;
          end else if (is_line) begin
            if (line_first) line_first <= 1'b0;
            else begin
              if (e2 > -$signed({dy[10], dy})) ax <= sxn ? ax - 1'b1 : ax + 1'b1;
              if (e2 < $signed({dx[10], dx})) ay <= syn ? ay - 1'b1 : ay + 1'b1;
              err <= err - ((e2 > -$signed({dy[10], dy})) ? dy : 11'sd0)
                         + ((e2 < $signed({dx[10], dx})) ? dx : 11'sd0);
              if (ax == bx && ay == by) state <= S_OUT;
            end
            if (!line_first && ax == bx && ay == by) state <= S_OUT;
          end else begin
            if (ax >= rx1) begin
              ax <= rx0; ay <= ay + 1'b1;
              if (ay >= ry1 && !on_screen) state <= S_OUT;
            end else ax <= ax + 1'b1;
          end
          if (!is_line && req == REQ_RECT && on_screen) line_first <= (ax >= rx1 && ay >= ry1);
        end
        S_WR: begin
          if (req == REQ_PIXEL || (req == REQ_RECT && line_first)) state <= S_OUT;
          else state <= S_DOT;
        end
        S_RD: state <= S_OUT;
        S_OUT: begin
          if (m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (state == S_RD) out_data <= rdata;
    end
  end

`ifndef SYNTHESIS
  a_one_hot: assert property (@(posedge clk) disable iff (rst) $onehot(state))
    else $error("state not one-hot");
  a_no_take_busy: assert property (@(posedge clk) disable iff (rst)
      m_tvalid |-> !s_tready) else $error("take while result pending");
  a_read_zero: assert property (@(posedge clk) disable iff (rst)
      (m_tvalid && req != REQ_READ) |-> out_data == 8'h00)
    else $error("non-read data not zero");
  a_wr_after_dot: assert property (@(posedge clk) disable iff (rst)
      state == S_WR |-> $past(state) == S_DOT) else $error("write without read");
`endif

endmodule
